// ----- design/psm_pkg.sv -----
// Shared types, constants and tables of the periodic state spectral model.
package psm_pkg;

	localparam int NUM_PERIODS_DEF = 24;
	localparam logic [31:0] BASE_PERIOD_RST = 32'd604800;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [1:0] REG_MODEL_ORDER = 2'd0;
	localparam logic [1:0] REG_AMP_THRESH = 2'd1;
	localparam logic [1:0] REG_BASE_PERIOD = 2'd2;

	localparam logic [63:0] CORDIC_K = 64'd652032874;
	localparam logic [5:0] STEPS_DIV = 6'd63;
	localparam logic [5:0] STEPS_MUL = 6'd63;
	localparam logic [5:0] STEPS_SQRT = 6'd31;
	localparam logic [5:0] STEPS_CORDIC = 6'd15;

	typedef struct packed {
		logic        cmd;
		logic [31:0] time_req;
		logic        observed_state;
		logic        batch_end;
	} item_t;

	typedef struct packed {
		logic [15:0] probability;
		logic        accepted;
	} result_t;

	typedef enum logic [2:0] {
		OP_DIV,
		OP_MUL,
		OP_SQRT,
		OP_ROT,
		OP_VEC
	} op_t;

	typedef struct packed {
		logic        start;
		op_t         op;
		logic [63:0] a;
		logic [63:0] b;
	} unit_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] res0;
		logic [63:0] res1;
	} unit_rsp_t;

	// arctangent of 2^-i in Q0.24 turns
	function automatic logic [23:0] atan_turns(input logic [3:0] i);
		logic [23:0] v;
		case (i)
			4'd0:    v = 24'd2097152;
			4'd1:    v = 24'd1238021;
			4'd2:    v = 24'd654136;
			4'd3:    v = 24'd332050;
			4'd4:    v = 24'd166669;
			4'd5:    v = 24'd83416;
			4'd6:    v = 24'd41718;
			4'd7:    v = 24'd20860;
			4'd8:    v = 24'd10430;
			4'd9:    v = 24'd5215;
			4'd10:   v = 24'd2608;
			4'd11:   v = 24'd1304;
			4'd12:   v = 24'd652;
			4'd13:   v = 24'd326;
			4'd14:   v = 24'd163;
			default: v = 24'd81;
		endcase
		return v;
	endfunction

endpackage

// ----- design/psm_unit.sv -----
// Shared iterative unit: divide, multiply, square root and both CORDIC modes.
module psm_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  psm_pkg::unit_req_t  req,
	output psm_pkg::unit_rsp_t  rsp
);

	logic [63:0] x_q, y_q, z_q;
	logic [5:0] cnt_q, last_q;
	logic busy_q, done_q, zero_q;
	logic [1:0] quad_q;
	psm_pkg::op_t op_q;

	logic [63:0] x_n, y_n, z_n;
	logic [32:0] trial, diff;
	logic ge;
	logic [63:0] sum;
	logic [3:0] sh;
	logic signed [63:0] dx, dy;
	logic [63:0] at;
	logic [15:0] rot_s16, rot_r;
	logic [1:0] rot_q;

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		logic signed [15:0] r;
		if (v > 64'sd32767) r = 16'sh7FFF;
		else if (v < -64'sd32768) r = 16'sh8000;
		else r = v[15:0];
		return r;
	endfunction

	function automatic logic signed [15:0] neg16(input logic signed [15:0] v);
		return (v == 16'sh8000) ? 16'sh7FFF : -v;
	endfunction

	// one iteration of the active operation
	always_comb begin
		sh = cnt_q[3:0];
		at = {40'b0, psm_pkg::atan_turns(sh)};
		trial = {y_q[31:0], x_q[63]};
		diff = trial - {1'b0, z_q[31:0]};
		ge = trial >= {1'b0, z_q[31:0]};
		sum = y_q + z_q;
		dx = $signed(y_q) >>> sh;
		dy = $signed(x_q) >>> sh;
		x_n = x_q;
		y_n = y_q;
		z_n = z_q;
		unique case (op_q)
			psm_pkg::OP_DIV: begin
				y_n = {32'b0, ge ? diff[31:0] : trial[31:0]};
				x_n = {x_q[62:0], ge};
			end
			psm_pkg::OP_MUL: begin
				if (y_q[0]) z_n = z_q + x_q;
				x_n = x_q << 1;
				y_n = y_q >> 1;
			end
			psm_pkg::OP_SQRT: begin
				if (x_q >= sum) begin
					x_n = x_q - sum;
					y_n = (y_q >> 1) + z_q;
				end else begin
					y_n = y_q >> 1;
				end
				z_n = z_q >> 2;
			end
			psm_pkg::OP_ROT: begin
				if (!z_q[63]) begin
					x_n = x_q - dx;
					y_n = y_q + dy;
					z_n = z_q - at;
				end else begin
					x_n = x_q + dx;
					y_n = y_q - dy;
					z_n = z_q + at;
				end
			end
			psm_pkg::OP_VEC: begin
				if ($signed(y_q) > 64'sd0) begin
					x_n = x_q + dx;
					y_n = y_q - dy;
					z_n = z_q + at;
				end else begin
					x_n = x_q - dx;
					y_n = y_q + dy;
					z_n = z_q - at;
				end
			end
			default: ;
		endcase
	end

	// quadrant fold of the rotation angle
	always_comb begin
		rot_s16 = req.a[15:0] + 16'h2000;
		rot_q = rot_s16[15:14];
		rot_r = req.a[15:0] - {rot_q, 14'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			last_q <= '0;
			op_q <= psm_pkg::OP_DIV;
			quad_q <= '0;
			zero_q <= 1'b0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				op_q <= req.op;
				unique case (req.op)
					psm_pkg::OP_DIV: begin
						x_q <= req.a;
						y_q <= '0;
						z_q <= {32'b0, req.b[31:0]};
						last_q <= psm_pkg::STEPS_DIV;
					end
					psm_pkg::OP_MUL: begin
						x_q <= req.a;
						y_q <= req.b;
						z_q <= '0;
						last_q <= psm_pkg::STEPS_MUL;
					end
					psm_pkg::OP_SQRT: begin
						x_q <= req.a;
						y_q <= '0;
						z_q <= 64'd1 << 62;
						last_q <= psm_pkg::STEPS_SQRT;
					end
					psm_pkg::OP_ROT: begin
						x_q <= psm_pkg::CORDIC_K;
						y_q <= '0;
						z_q <= {{40{rot_r[15]}}, rot_r, 8'b0};
						quad_q <= rot_q;
						last_q <= psm_pkg::STEPS_CORDIC;
					end
					psm_pkg::OP_VEC: begin
						zero_q <= (req.a == '0) && (req.b == '0);
						if (req.a[63]) begin
							x_q <= -req.a;
							y_q <= -req.b;
							z_q <= 64'h80_0000;
						end else begin
							x_q <= req.a;
							y_q <= req.b;
							z_q <= '0;
						end
						last_q <= psm_pkg::STEPS_CORDIC;
					end
					default: ;
				endcase
			end else if (busy_q) begin
				x_q <= x_n;
				y_q <= y_n;
				z_q <= z_n;
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == last_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	logic signed [15:0] cc, ss, cos_o, sin_o;
	logic [23:0] zr;

	always_comb begin
		cc = sat16(($signed(x_q) + 64'sd16384) >>> 15);
		ss = sat16(($signed(y_q) + 64'sd16384) >>> 15);
		unique case (quad_q)
			2'd0: begin cos_o = cc; sin_o = ss; end
			2'd1: begin cos_o = neg16(ss); sin_o = cc; end
			2'd2: begin cos_o = neg16(cc); sin_o = neg16(ss); end
			default: begin cos_o = ss; sin_o = neg16(cc); end
		endcase
		zr = z_q[23:0] + 24'd128;
		rsp.done = done_q;
		rsp.res0 = x_q;
		rsp.res1 = y_q;
		unique case (op_q)
			psm_pkg::OP_DIV: ;
			psm_pkg::OP_MUL: rsp.res0 = z_q;
			psm_pkg::OP_SQRT: rsp.res0 = y_q;
			psm_pkg::OP_ROT: begin
				rsp.res0 = {{48{cos_o[15]}}, cos_o};
				rsp.res1 = {{48{sin_o[15]}}, sin_o};
			end
			psm_pkg::OP_VEC: rsp.res0 = zero_q ? 64'd0 : {48'b0, zr[23:8]};
			default: ;
		endcase
	end

endmodule

// ----- design/periodic_state_spectral_model.sv -----
// Top level: sequencer, model state and configuration port of the spectral model.
// Observe: three 64-step divides and a 16-step CORDIC per period, all on the one shared
//   unit; a batch end adds amplitude, phase and ranking of every period.
// Predict: a gain divide, then the same per-period divides and CORDIC for each of
//   min(model_order, NUM_PERIODS) ranked components.
// Throughput: one item at a time; the next is taken once the sequencer is back in idle.
// Reset clears all sums, amplitudes, phases and counters and sets the identity ranking.
module periodic_state_spectral_model #(
	parameter int NUM_PERIODS = psm_pkg::NUM_PERIODS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  psm_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output psm_pkg::result_t               result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [psm_pkg::PADDR_W-1:0]    paddr,
	input  logic [psm_pkg::PDATA_W-1:0]    pwdata,
	output logic [psm_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready
);

	// index width for periods, and a counter width that can hold NUM_PERIODS itself
	localparam int KW = (NUM_PERIODS > 1) ? $clog2(NUM_PERIODS) : 1;
	localparam int RW = $clog2(NUM_PERIODS + 1);

	typedef enum logic [4:0] {
		S_IDLE,
		S_PER,
		S_MOD,
		S_ANG,
		S_ROT,
		S_PACC,
		S_PGAIN,
		S_RGAIN,
		S_RPER,
		S_BMC,
		S_QC,
		S_BMS,
		S_QS,
		S_SQC,
		S_SQS,
		S_SQRT,
		S_VEC,
		S_SROW,
		S_SCMP,
		S_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [4:0]  model_order_q;
	logic [15:0] amp_thresh_q;
	logic [31:0] base_period_q;

	// model state
	logic signed [47:0] scs_q [NUM_PERIODS];
	logic signed [47:0] sss_q [NUM_PERIODS];
	logic signed [47:0] tcs_q [NUM_PERIODS];
	logic signed [47:0] tss_q [NUM_PERIODS];
	logic [15:0] amp_q [NUM_PERIODS];
	logic [15:0] phase_q [NUM_PERIODS];
	logic [KW-1:0] rank_q [NUM_PERIODS];
	logic [31:0] ones_q, samples_q, first_q;
	logic signed [32:0] latest_q;
	logic pending_q;

	// item working registers
	psm_pkg::item_t item_q;
	logic acc_q;
	logic [KW-1:0] k_q, j_q, cnt_q;
	logic [RW-1:0] r_q;
	logic [31:0] per_q;
	logic [16:0] gain_q;
	logic short_q;
	logic qcn_q, qsn_q;
	logic [63:0] qcm_q, qsm_q, sq_q;
	logic [15:0] av_q;
	logic signed [32:0] prod_q;
	logic signed [39:0] est_q;

	logic result_valid_q;
	psm_pkg::result_t result_q;

	psm_pkg::unit_req_t ureq_q;
	psm_pkg::unit_rsp_t ursp;

	psm_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ureq_q),
		.rsp    (ursp)
	);

	function automatic psm_pkg::unit_req_t issue(input psm_pkg::op_t op,
			input logic [63:0] a, input logic [63:0] b);
		psm_pkg::unit_req_t r;
		r.start = 1'b1;
		r.op = op;
		r.a = a;
		r.b = b;
		return r;
	endfunction

	// remove the gain-weighted balance term; return sign and |residual| << 15
	function automatic logic [64:0] resid(input logic signed [47:0] sv,
			input logic signed [47:0] tv, input logic [63:0] prod);
		logic [63:0] rnd;
		logic signed [49:0] b50, r50;
		logic [49:0] mag;
		rnd = (prod + 64'd32768) >> 16;
		b50 = $signed({2'b0, rnd[47:0]});
		if (tv < 0) b50 = -b50;
		r50 = $signed({{2{sv[47]}}, sv}) - b50;
		mag = r50[49] ? 50'(-r50) : 50'(r50);
		return {r50[49], mag[48:0], 15'b0};
	endfunction

	function automatic logic [63:0] tmag(input logic signed [47:0] tv);
		logic [47:0] m;
		m = tv[47] ? 48'(-tv) : 48'(tv);
		return {16'b0, m};
	endfunction

	// derived values from the unit's result
	logic [31:0] per_n;
	logic [RW-1:0] m_lim;
	logic [33:0] three_per, dur2;
	logic [31:0] span;
	logic [64:0] res_c, res_s;
	logic [63:0] root_rnd, amp64;
	logic [15:0] amp_sat, amp_n;
	logic [63:0] qc_val, qs_val;
	logic beat_win;
	logic [KW-1:0] cnt_n;
	logic [15:0] ang_obs;
	logic [31:0] ones_n, samples_n;
	logic newer;
	logic signed [39:0] est_rnd;
	logic [15:0] prob_n;
	logic [RW-1:0] r_n;

	always_comb begin
		per_n = (ursp.res0[31:0] == '0) ? 32'd1 : ursp.res0[31:0];
		m_lim = (32'(model_order_q) > NUM_PERIODS) ? RW'(NUM_PERIODS) : RW'(model_order_q);
		three_per = {2'b0, per_n} + {1'b0, per_n, 1'b0};
		span = latest_q[31:0] - first_q;
		dur2 = {1'b0, span, 1'b0};
		res_c = resid(scs_q[k_q], tcs_q[k_q], ursp.res0);
		res_s = resid(sss_q[k_q], tss_q[k_q], ursp.res0);
		root_rnd = ursp.res0 + 64'd8192;
		amp64 = root_rnd >> 14;
		amp_sat = (amp64[63:16] != '0) ? 16'hFFFF : amp64[15:0];
		amp_n = (short_q || amp_sat < amp_thresh_q) ? 16'd0 : amp_sat;
		qc_val = qcn_q ? -qcm_q : qcm_q;
		qs_val = qsn_q ? -qsm_q : qsm_q;
		beat_win = (amp_q[j_q] > av_q) || ((amp_q[j_q] == av_q) && (j_q < k_q));
		cnt_n = cnt_q + KW'(beat_win);
		ang_obs = ursp.res0[15:0];
		ones_n = ones_q + 32'(item_q.observed_state);
		samples_n = samples_q + 32'd1;
		newer = $signed({1'b0, item.time_req}) > latest_q;
		est_rnd = (est_q + 40'sd16384) >>> 15;
		prob_n = (est_q <= 40'sd0) ? 16'd0 :
			(est_rnd > 40'sd65535) ? 16'hFFFF : est_rnd[15:0];
		r_n = r_q + RW'(1);
	end

	assign item_ready = (state_q == S_IDLE);
	assign result_valid = result_valid_q;
	assign result = result_q;
	assign pready = 1'b1;

	// register read
	always_comb begin
		unique case (paddr[3:2])
			psm_pkg::REG_MODEL_ORDER: prdata = {27'b0, model_order_q};
			psm_pkg::REG_AMP_THRESH:  prdata = {16'b0, amp_thresh_q};
			psm_pkg::REG_BASE_PERIOD: prdata = base_period_q;
			default:                  prdata = '0;
		endcase
	end

	// register write, taken on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_order_q <= '0;
			amp_thresh_q <= '0;
			base_period_q <= psm_pkg::BASE_PERIOD_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				psm_pkg::REG_MODEL_ORDER: model_order_q <= pwdata[4:0];
				psm_pkg::REG_AMP_THRESH:  amp_thresh_q <= pwdata[15:0];
				psm_pkg::REG_BASE_PERIOD: base_period_q <= pwdata;
				default: ;
			endcase
		end
	end

	// sequencer: every state except idle, accumulate, ranking and done waits on the shared unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ureq_q <= '0;
			result_valid_q <= 1'b0;
			result_q <= '0;
			for (int i = 0; i < NUM_PERIODS; i++) begin
				scs_q[i] <= '0;
				sss_q[i] <= '0;
				tcs_q[i] <= '0;
				tss_q[i] <= '0;
				amp_q[i] <= '0;
				phase_q[i] <= '0;
				rank_q[i] <= KW'(i);
			end
			ones_q <= '0;
			samples_q <= '0;
			first_q <= '0;
			latest_q <= -33'sd1;
			pending_q <= 1'b0;
			item_q <= '0;
			acc_q <= 1'b0;
			k_q <= '0;
			j_q <= '0;
			cnt_q <= '0;
			r_q <= '0;
			per_q <= '0;
			gain_q <= '0;
			short_q <= 1'b0;
			qcn_q <= 1'b0;
			qsn_q <= 1'b0;
			qcm_q <= '0;
			qsm_q <= '0;
			sq_q <= '0;
			av_q <= '0;
			prod_q <= '0;
			est_q <= '0;
		end else begin
			ureq_q.start <= 1'b0;
			if (result_valid_q && result_ready) result_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						item_q <= item;
						acc_q <= 1'b0;
						if (!item.cmd) begin
							if (newer && samples_q != 32'hFFFF_FFFF) begin
								acc_q <= 1'b1;
								if (samples_q == '0) first_q <= item.time_req;
								k_q <= '0;
								ureq_q <= issue(psm_pkg::OP_DIV, {32'b0, base_period_q}, 64'd1);
								state_q <= S_PER;
							end else if (item.batch_end && pending_q) begin
								ureq_q <= issue(psm_pkg::OP_DIV, {16'b0, ones_q, 16'b0},
									{32'b0, samples_q});
								state_q <= S_RGAIN;
							end else begin
								state_q <= S_DONE;
							end
						end else begin
							ureq_q <= issue(psm_pkg::OP_DIV, {16'b0, ones_q, 16'b0},
								{32'b0, samples_q});
							state_q <= S_PGAIN;
						end
					end
				end

				// period, phase within period, angle in turns, then sine and cosine
				S_PER: if (ursp.done) begin
					per_q <= per_n;
					ureq_q <= issue(psm_pkg::OP_DIV, {32'b0, item_q.time_req}, {32'b0, per_n});
					state_q <= S_MOD;
				end
				S_MOD: if (ursp.done) begin
					ureq_q <= issue(psm_pkg::OP_DIV, {16'b0, ursp.res1[31:0], 16'b0},
						{32'b0, per_q});
					state_q <= S_ANG;
				end
				S_ANG: if (ursp.done) begin
					if (item_q.cmd)
						ureq_q <= issue(psm_pkg::OP_ROT, {48'b0, ang_obs - phase_q[k_q]}, 64'd0);
					else
						ureq_q <= issue(psm_pkg::OP_ROT, {48'b0, ang_obs}, 64'd0);
					state_q <= S_ROT;
				end
				S_ROT: if (ursp.done) begin
					if (item_q.cmd) begin
						prod_q <= $signed({1'b0, amp_q[k_q]}) * $signed(ursp.res0[15:0]);
						state_q <= S_PACC;
					end else begin
						tcs_q[k_q] <= tcs_q[k_q] + {{32{ursp.res0[15]}}, ursp.res0[15:0]};
						tss_q[k_q] <= tss_q[k_q] + {{32{ursp.res1[15]}}, ursp.res1[15:0]};
						if (item_q.observed_state) begin
							scs_q[k_q] <= scs_q[k_q] + {{32{ursp.res0[15]}}, ursp.res0[15:0]};
							sss_q[k_q] <= sss_q[k_q] + {{32{ursp.res1[15]}}, ursp.res1[15:0]};
						end
						if (k_q == KW'(NUM_PERIODS - 1)) begin
							ones_q <= ones_n;
							samples_q <= samples_n;
							latest_q <= $signed({1'b0, item_q.time_req});
							pending_q <= 1'b1;
							if (item_q.batch_end) begin
								ureq_q <= issue(psm_pkg::OP_DIV, {16'b0, ones_n, 16'b0},
									{32'b0, samples_n});
								state_q <= S_RGAIN;
							end else begin
								state_q <= S_DONE;
							end
						end else begin
							k_q <= k_q + KW'(1);
							ureq_q <= issue(psm_pkg::OP_DIV, {32'b0, base_period_q},
								64'(32'(k_q) + 32'd2));
							state_q <= S_PER;
						end
					end
				end

				// prediction: gain, then one ranked component per pass
				S_PGAIN: if (ursp.done) begin
					est_q <= {8'b0, (samples_q == '0) ? 17'd0 : ursp.res0[16:0], 15'b0};
					r_q <= '0;
					if (m_lim == '0) begin
						state_q <= S_DONE;
					end else begin
						k_q <= rank_q[0];
						ureq_q <= issue(psm_pkg::OP_DIV, {32'b0, base_period_q},
							64'(32'(rank_q[0]) + 32'd1));
						state_q <= S_PER;
					end
				end
				S_PACC: begin
					est_q <= est_q + {{6{prod_q[32]}}, prod_q, 1'b0};
					r_q <= r_n;
					if (r_n == m_lim) begin
						state_q <= S_DONE;
					end else begin
						k_q <= rank_q[r_n[KW-1:0]];
						ureq_q <= issue(psm_pkg::OP_DIV, {32'b0, base_period_q},
							64'(32'(rank_q[r_n[KW-1:0]]) + 32'd1));
						state_q <= S_PER;
					end
				end

				// recompute: amplitude and phase of every period
				S_RGAIN: if (ursp.done) begin
					gain_q <= ursp.res0[16:0];
					k_q <= '0;
					ureq_q <= issue(psm_pkg::OP_DIV, {32'b0, base_period_q}, 64'd1);
					state_q <= S_RPER;
				end
				S_RPER: if (ursp.done) begin
					short_q <= three_per > dur2;
					ureq_q <= issue(psm_pkg::OP_MUL, tmag(tcs_q[k_q]), {47'b0, gain_q});
					state_q <= S_BMC;
				end
				S_BMC: if (ursp.done) begin
					qcn_q <= res_c[64];
					ureq_q <= issue(psm_pkg::OP_DIV, res_c[63:0], {32'b0, samples_q});
					state_q <= S_QC;
				end
				S_QC: if (ursp.done) begin
					qcm_q <= ursp.res0;
					ureq_q <= issue(psm_pkg::OP_MUL, tmag(tss_q[k_q]), {47'b0, gain_q});
					state_q <= S_BMS;
				end
				S_BMS: if (ursp.done) begin
					qsn_q <= res_s[64];
					ureq_q <= issue(psm_pkg::OP_DIV, res_s[63:0], {32'b0, samples_q});
					state_q <= S_QS;
				end
				S_QS: if (ursp.done) begin
					qsm_q <= ursp.res0;
					ureq_q <= issue(psm_pkg::OP_MUL, qcm_q, qcm_q);
					state_q <= S_SQC;
				end
				S_SQC: if (ursp.done) begin
					sq_q <= ursp.res0;
					ureq_q <= issue(psm_pkg::OP_MUL, qsm_q, qsm_q);
					state_q <= S_SQS;
				end
				S_SQS: if (ursp.done) begin
					ureq_q <= issue(psm_pkg::OP_SQRT, sq_q + ursp.res0, 64'd0);
					state_q <= S_SQRT;
				end
				S_SQRT: if (ursp.done) begin
					amp_q[k_q] <= amp_n;
					ureq_q <= issue(psm_pkg::OP_VEC, qc_val, qs_val);
					state_q <= S_VEC;
				end
				S_VEC: if (ursp.done) begin
					phase_q[k_q] <= ursp.res0[15:0];
					if (k_q == KW'(NUM_PERIODS - 1)) begin
						k_q <= '0;
						state_q <= S_SROW;
					end else begin
						k_q <= k_q + KW'(1);
						ureq_q <= issue(psm_pkg::OP_DIV, {32'b0, base_period_q},
							64'(32'(k_q) + 32'd2));
						state_q <= S_RPER;
					end
				end

				// ranking: a period's rank counts the periods that beat it
				S_SROW: begin
					av_q <= amp_q[k_q];
					j_q <= '0;
					cnt_q <= '0;
					state_q <= S_SCMP;
				end
				S_SCMP: begin
					if (j_q == KW'(NUM_PERIODS - 1)) begin
						rank_q[cnt_n] <= k_q;
						if (k_q == KW'(NUM_PERIODS - 1)) begin
							pending_q <= 1'b0;
							state_q <= S_DONE;
						end else begin
							k_q <= k_q + KW'(1);
							state_q <= S_SROW;
						end
					end else begin
						j_q <= j_q + KW'(1);
						cnt_q <= cnt_n;
					end
				end

				// hold the result until the output register is free
				S_DONE: begin
					if (!result_valid_q || result_ready) begin
						result_valid_q <= 1'b1;
						result_q.accepted <= item_q.cmd ? 1'b0 : acc_q;
						result_q.probability <= item_q.cmd ? prob_n : 16'd0;
						state_q <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- tb/periodic_state_spectral_model_tb.sv -----
// Self-checking testbench of the periodic state spectral model.
`timescale 1ns / 1ps

module periodic_state_spectral_model_tb;

	localparam int NP = psm_pkg::NUM_PERIODS_DEF;
	localparam longint CYCLE_LIMIT = 80_000_000;
	// arctangent of 2^-i, Q0.24 turns
	localparam longint ATAN_Q24 [16] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
		41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	psm_pkg::item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	psm_pkg::result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [psm_pkg::PADDR_W-1:0] paddr = '0;
	logic [psm_pkg::PDATA_W-1:0] pwdata = '0;
	logic [psm_pkg::PDATA_W-1:0] prdata;
	logic pready;

	periodic_state_spectral_model DUT (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	// Stimulus and expectation stores
	psm_pkg::item_t beats_to_send[$];
	psm_pkg::result_t expected_results[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	longint cycles = 0;

	// Shadow copy of the block's configuration and learned state
	bit [4:0] cfg_order;
	bit [15:0] cfg_thresh;
	bit [31:0] cfg_base;
	longint st_cos[NP], st_sin[NP], tm_cos[NP], tm_sin[NP];
	longint amp_of[NP], phase_of[NP];
	int rank_of[NP];
	bit [31:0] ones_n, samples_n, first_t;
	longint latest_t;
	bit recompute_due;

	// Current observation clock for the generator
	longint obs_clock;

	function automatic longint sat15(input longint v);
		return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
	endfunction

	function automatic longint period_len(input int k);
		longint p;
		p = longint'(cfg_base / (k + 1));
		return (p == 0) ? 1 : p;
	endfunction

	function automatic bit [15:0] turn_of(input bit [31:0] t, input int k);
		longint p, r;
		p = period_len(k);
		r = longint'(t) % p;
		return 16'((r << 16) / p);
	endfunction

	// Rotate a unit vector to the angle (Q0.16 turns); Q1.15 cosine and sine
	function automatic void rotate_unit(input bit [15:0] ang, output longint c, output longint s);
		bit [31:0] quad;
		longint r, x, y, z, dx, dy, cc, ss;
		quad = ((32'(ang) + 32'h2000) >> 14) & 32'd3;
		r = longint'((32'(ang) - quad * 32'h4000) & 32'hFFFF);
		if (r >= 32768) r -= 65536;
		z = r * 256;
		x = 652032874;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_Q24[i];
			end else begin
				x += dx; y -= dy; z += ATAN_Q24[i];
			end
		end
		cc = sat15((x + 16384) >>> 15);
		ss = sat15((y + 16384) >>> 15);
		case (quad)
			0: begin c = cc; s = ss; end
			1: begin c = sat15(-ss); s = cc; end
			2: begin c = sat15(-cc); s = sat15(-ss); end
			default: begin c = ss; s = sat15(-cc); end
		endcase
	endfunction

	// Angle of (x, y) in Q0.16 turns
	function automatic longint angle_of(input longint x, input longint y);
		bit [31:0] z;
		longint nx;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			x = -x; y = -y; z = 32'h800000;
		end
		for (int i = 0; i < 16; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i); y -= x >>> i; z += 32'(ATAN_Q24[i]);
			end else begin
				nx = x - (y >>> i); y += x >>> i; z -= 32'(ATAN_Q24[i]);
			end
			x = nx;
		end
		return longint'(((z + 32'd128) >> 8) & 32'hFFFF);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned root, b;
		root = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v -= root + b; root = (root >> 1) + b;
			end else root >>= 1;
			b >>= 2;
		end
		return root;
	endfunction

	function automatic longint mean_gain();
		if (samples_n == 0) return 0;
		return longint'((64'(ones_n) << 16) / 64'(samples_n));
	endfunction

	// Remove the mean's share from a state sum and scale by the sample count
	function automatic longint debias(input longint st, input longint tm, input longint g);
		longint unsigned mag, bal, q;
		longint r;
		mag = (tm < 0) ? -tm : tm;
		bal = (64'(g) * mag + 32768) >> 16;
		r = st - ((tm < 0) ? -longint'(bal) : longint'(bal));
		q = (64'((r < 0) ? -r : r) << 15) / 64'(samples_n);
		return (r < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic void rebuild_components();
		longint g, qc, qs, v;
		longint unsigned ac, as_, amp, dur2;
		int j;
		g = mean_gain();
		dur2 = 64'(latest_t - longint'(first_t)) * 2;
		for (int k = 0; k < NP; k++) begin
			qc = debias(st_cos[k], tm_cos[k], g);
			qs = debias(st_sin[k], tm_sin[k], g);
			ac = (qc < 0) ? -qc : qc;
			as_ = (qs < 0) ? -qs : qs;
			amp = (int_sqrt(ac * ac + as_ * as_) + 8192) >> 14;
			if (amp > 65535) amp = 65535;
			if (64'(3 * period_len(k)) > dur2) amp = 0;
			if (amp < cfg_thresh) amp = 0;
			amp_of[k] = longint'(amp);
			phase_of[k] = angle_of(qc, qs);
		end
		// stable insertion sort, strongest first
		for (int r = 0; r < NP; r++) rank_of[r] = r;
		for (int r = 1; r < NP; r++) begin
			v = rank_of[r];
			j = r;
			while (j > 0 && amp_of[v] > amp_of[rank_of[j - 1]]) begin
				rank_of[j] = rank_of[j - 1];
				j--;
			end
			rank_of[j] = int'(v);
		end
		recompute_due = 1'b0;
	endfunction

	function automatic psm_pkg::result_t model_step(input psm_pkg::item_t it);
		psm_pkg::result_t res;
		longint c, s, est;
		int m, p;
		bit [15:0] th;
		res = '0;
		if (it.cmd == 1'b0) begin
			if (longint'(it.time_req) > latest_t && samples_n != 32'hFFFFFFFF) begin
				if (samples_n == 0) first_t = it.time_req;
				for (int k = 0; k < NP; k++) begin
					rotate_unit(turn_of(it.time_req, k), c, s);
					tm_cos[k] += c;
					tm_sin[k] += s;
					if (it.observed_state) begin
						st_cos[k] += c; st_sin[k] += s;
					end
				end
				ones_n += it.observed_state;
				samples_n++;
				latest_t = longint'(it.time_req);
				recompute_due = 1'b1;
				res.accepted = 1'b1;
			end
			if (it.batch_end && recompute_due) rebuild_components();
		end else begin
			est = mean_gain() << 15;
			m = (cfg_order > NP) ? NP : cfg_order;
			for (int r = 0; r < m; r++) begin
				p = rank_of[r] % NP;
				th = turn_of(it.time_req, p) - 16'(phase_of[p]);
				rotate_unit(th, c, s);
				est += 2 * amp_of[p] * c;
			end
			if (est > 0) begin
				est = (est + 16384) >>> 15;
				res.probability = (est > 65535) ? 16'hFFFF : 16'(est);
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		mismatches++;
	endtask

	// Driver: hold each beat until accepted, then advance from the queue
	always @(posedge clk or negedge arst_n) begin
		logic next_valid;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			next_valid = item_valid;
			if (item_valid && item_ready) begin
				expected_results.push_back(model_step(item));
				next_valid = 1'b0;
			end
			if (!next_valid && beats_to_send.size() != 0
					&& $urandom_range(99) >= send_idle_pct) begin
				item <= beats_to_send.pop_front();
				next_valid = 1'b1;
			end
			item_valid <= next_valid;
		end
	end

	// Monitor: compare each result beat against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		psm_pkg::result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result beat", 1, 0);
				end else begin
					want = expected_results.pop_front();
					if (result.probability !== want.probability)
						report_mismatch("probability", result.probability, want.probability);
					if (result.accepted !== want.accepted)
						report_mismatch("accepted", result.accepted, want.accepted);
				end
			end
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Hold until the block has produced everything it owes, then let it settle;
	// sample between edges so the driver's updates of this cycle are visible
	task automatic drain();
		while (beats_to_send.size() != 0 || item_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (50) @(posedge clk);
	endtask

	// APB write: setup then access; mirror into the shadow config at the same time
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= psm_pkg::PADDR_W'({idx, 2'b00}); pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			psm_pkg::REG_MODEL_ORDER: cfg_order = value[4:0];
			psm_pkg::REG_AMP_THRESH: cfg_thresh = value[15:0];
			psm_pkg::REG_BASE_PERIOD: cfg_base = value;
			default: ;
		endcase
	endtask

	task automatic push_beat(input bit cmd, input bit [31:0] t, input bit st, input bit be);
		psm_pkg::item_t it;
		it.cmd = cmd; it.time_req = t; it.observed_state = st; it.batch_end = be;
		beats_to_send.push_back(it);
	endtask

	// Mostly fresh observations whose state follows the base period, some stale ones,
	// predictions around the current time and a few anywhere
	task automatic queue_random(input int count);
		longint step_max, ph;
		int pick;
		bit st;
		step_max = longint'(cfg_base) / 6 + 1;
		if (step_max > 2_000_000) step_max = 2_000_000;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				if (obs_clock + step_max < 64'hF000_0000)
					obs_clock += $urandom_range(int'(step_max), 1);
				ph = obs_clock % longint'(cfg_base);
				st = ($urandom_range(99) < 80) ? (ph < longint'(cfg_base) / 2)
					: 1'($urandom_range(1));
				push_beat(1'b0, 32'(obs_clock), st, $urandom_range(99) < 7);
			end else if (pick < 62) begin
				push_beat(1'b0, $urandom_range(int'(obs_clock[31:0]), 0),
					1'($urandom_range(1)), $urandom_range(99) < 15);
			end else if (pick < 92) begin
				push_beat(1'b1, 32'(obs_clock + $urandom_range(int'(step_max) * 4, 0)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			end else begin
				push_beat(1'b1, $urandom, 1'($urandom_range(1)), 1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		cfg_order = 0; cfg_thresh = 0; cfg_base = psm_pkg::BASE_PERIOD_RST;
		for (int k = 0; k < NP; k++) begin
			st_cos[k] = 0; st_sin[k] = 0; tm_cos[k] = 0; tm_sin[k] = 0;
			amp_of[k] = 0; phase_of[k] = 0; rank_of[k] = k;
		end
		ones_n = 0; samples_n = 0; first_t = 0; latest_t = -1; recompute_due = 0;
		obs_clock = 1_000_000;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset configuration: first sample at time zero, a stale repeat,
		// batch end on a predict, batch end with nothing pending, batch end on a
		// rejected observation that still has pending data
		push_beat(1'b0, 32'd0, 1'b1, 1'b0);
		push_beat(1'b0, 32'd0, 1'b0, 1'b0);
		push_beat(1'b0, 32'd1000, 1'b0, 1'b1);
		push_beat(1'b1, 32'd0, 1'b0, 1'b1);
		push_beat(1'b0, 32'd500, 1'b1, 1'b1);
		push_beat(1'b0, 32'd1_000_000, 1'b1, 1'b0);
		push_beat(1'b0, 32'd1000, 1'b1, 1'b1);
		push_beat(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0);
		drain();

		// Directed, largest model order and above it
		write_reg(psm_pkg::REG_MODEL_ORDER, 32'd24);
		push_beat(1'b1, 32'd302400, 1'b0, 1'b0);
		push_beat(1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0);
		drain();
		write_reg(psm_pkg::REG_MODEL_ORDER, 32'd31);
		push_beat(1'b1, 32'd0, 1'b0, 1'b0);
		push_beat(1'b1, 32'h8000_0000, 1'b1, 1'b1);
		drain();

		// Random phases: sweep idle pressure and configuration extremes
		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 72; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 72; end
				default: begin send_idle_pct = 21; recv_stall_pct = 21; end
			endcase
			case (ph)
				0: begin
					write_reg(psm_pkg::REG_MODEL_ORDER, 32'd4);
					write_reg(psm_pkg::REG_BASE_PERIOD, 32'd86400);
				end
				1: begin
					write_reg(psm_pkg::REG_AMP_THRESH, 32'd2000);
					write_reg(psm_pkg::REG_MODEL_ORDER, 32'd24);
				end
				2: begin
					write_reg(psm_pkg::REG_BASE_PERIOD, 32'd1);
					write_reg(psm_pkg::REG_AMP_THRESH, 32'd0);
				end
				3: begin
					write_reg(psm_pkg::REG_BASE_PERIOD, 32'd3600);
					write_reg(psm_pkg::REG_MODEL_ORDER, 32'd31);
				end
				4: begin
					write_reg(psm_pkg::REG_BASE_PERIOD, 32'hFFFF_FFFF);
					write_reg(psm_pkg::REG_AMP_THRESH, 32'd65535);
				end
				default: begin
					write_reg(psm_pkg::REG_BASE_PERIOD, psm_pkg::BASE_PERIOD_RST);
					write_reg(psm_pkg::REG_AMP_THRESH, 32'd300);
					write_reg(psm_pkg::REG_MODEL_ORDER, 32'd0);
				end
			endcase
			queue_random(240);
			drain();
		end

		// Last, the newest possible observation: nothing after it can be taken
		send_idle_pct = 21; recv_stall_pct = 21;
		write_reg(psm_pkg::REG_MODEL_ORDER, 32'd24);
		push_beat(1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1);
		push_beat(1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1);
		push_beat(1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0);
		drain();
		repeat (200) @(posedge clk);

		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
